/* hdl/border_connected_region_fill_unit_defines.svh */
// ----------------------------------------------------------------------------
// Border-connected region fill: assertion macros
// Shared helpers for the concurrent checks of the fill unit.
// ----------------------------------------------------------------------------
`ifndef BORDER_CONNECTED_REGION_FILL_UNIT_DEFINES_SVH
`define BORDER_CONNECTED_REGION_FILL_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BCRF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, checked outside reset.
`define BCRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

/* hdl/bcrf_pkg.sv */
// ----------------------------------------------------------------------------
// Border-connected region fill package
// Sizes, word types and controller states shared by the fill unit.
// ----------------------------------------------------------------------------
package bcrf_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int ROW_W     = 6;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

  typedef struct packed {
    logic [MAX_COLS-1:0] row_bits;
    logic                last_row;
  } in_word_t;

  typedef struct packed {
    logic [ROW_W-1:0]    row_index;
    logic [MAX_COLS-1:0] filled_bits;
    logic                last_out;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SW_RD,
    ST_SW_WR,
    ST_EMIT
  } state_t;

endpackage

/* hdl/bcrf_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module bcrf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* hdl/border_connected_region_fill_unit.sv */
// ----------------------------------------------------------------------------
// Border-connected region fill unit
// Loads a grid one row per word, keeps the open cells that reach the border
// and sends the filled grid back row by row.
//
//   Port group   Kind           Handshake
//   din          input word     start high and busy low
//   dout         result word    done valid per word, no stall
//   cfg_*        register write cfg_we high
//
// A row without last_row leaves the unit idle. The last row starts the fill:
// alternating down and up sweeps over the keep memory, each row read, then
// modified and written, until a sweep after the first changes nothing;
// then h result words follow, one per cycle. The sweep count depends on
// the shape of the open regions. Reset is synchronous and needs no
// clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
`include "border_connected_region_fill_unit_defines.svh"

module border_connected_region_fill_unit
  import bcrf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_word_t             din,
  output logic                 done,
  output out_word_t            dout,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  state_t              state, state_next;
  logic [CNT_W-1:0]    num_rows, num_cols, rows_loaded;
  logic [ROW_W-1:0]    row;
  logic                dir_up, first_pass, changed;
  logic [MAX_COLS-1:0] behind;
  logic                emit_vld, emit_last;
  logic [ROW_W-1:0]    emit_row;

  logic [CNT_W-1:0]    h, w;
  logic [ROW_W-1:0]    h_last, ahead;
  logic [MAX_COLS-1:0] colmask, border, open_row, old_row, ahead_row, seed, new_row;
  logic [MAX_COLS-1:0] fill_up, fill_dn, o_rev, s_rev;
  logic [MAX_COLS-1:0] cell_q, keep_a, keep_b;
  logic                accept, pass_end, keep_we;
  logic [ROW_W-1:0]    keep_ra;

  function automatic logic [MAX_COLS-1:0] rev(input logic [MAX_COLS-1:0] x);
    logic [MAX_COLS-1:0] y;
    for (int i = 0; i < MAX_COLS; i++) begin
      y[i] = x[MAX_COLS-1-i];
    end
    return y;
  endfunction

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  assign h = (num_rows == '0) ? CNT_W'(1) :
             (num_rows > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : num_rows;
  assign w = (num_cols == '0) ? CNT_W'(1) :
             (num_cols > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : num_cols;
  assign h_last  = ROW_W'(h - CNT_W'(1));
  assign colmask = (w == CNT_W'(MAX_COLS)) ? '1 :
                   ((MAX_COLS'(1) << w[ROW_W-1:0]) - MAX_COLS'(1));

  assign ahead    = dir_up ? (row - ROW_W'(1)) : (row + ROW_W'(1));
  assign pass_end = dir_up ? (row == '0) : (row == h_last);

  bcrf_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_cell_ram (
    .clk     (clk),
    .we      (accept && (rows_loaded < CNT_W'(MAX_ROWS))),
    .waddr   (rows_loaded[ROW_W-1:0]),
    .wdata   (din.row_bits),
    .raddr_a (row),
    .rdata_a (cell_q),
    .raddr_b (row),
    .rdata_b ()
  );

  assign keep_ra = row;
  assign keep_we = (state == ST_SW_WR);

  bcrf_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_keep_ram (
    .clk     (clk),
    .we      (keep_we),
    .waddr   (row),
    .wdata   (new_row),
    .raddr_a (keep_ra),
    .rdata_a (keep_a),
    .raddr_b (ahead),
    .rdata_b (keep_b)
  );

  always_comb begin
    open_row  = ({1'b0, row} < rows_loaded) ? (cell_q & colmask) : '0;
    old_row   = first_pass ? '0 : keep_a;
    ahead_row = (first_pass || pass_end) ? '0 : keep_b;
    if (row == '0 || row == h_last) begin
      border = '1;
    end else begin
      border = MAX_COLS'(1) | (MAX_COLS'(1) << ROW_W'(w - CNT_W'(1)));
    end
    seed    = open_row & (behind | ahead_row | border | old_row);
    fill_up = ((open_row + seed) ^ open_row) & open_row;
    o_rev   = rev(open_row);
    s_rev   = rev(seed);
    fill_dn = rev(((o_rev + s_rev) ^ o_rev) & o_rev);
    new_row = fill_up | fill_dn | seed;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && din.last_row) begin
          state_next = ST_SW_RD;
        end
      end
      ST_SW_RD: state_next = ST_SW_WR;
      ST_SW_WR: begin
        if (pass_end && !first_pass && !changed && (new_row == old_row)) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_SW_RD;
        end
      end
      ST_EMIT: begin
        if (row == h_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      num_rows    <= CNT_W'(MAX_ROWS);
      num_cols    <= CNT_W'(MAX_COLS);
      rows_loaded <= '0;
      row         <= '0;
      dir_up      <= 1'b0;
      first_pass  <= 1'b1;
      changed     <= 1'b0;
      behind      <= '0;
      emit_vld    <= 1'b0;
      emit_row    <= '0;
      emit_last   <= 1'b0;
    end else begin
      state    <= state_next;
      emit_vld <= 1'b0;
      if (cfg_we && cfg_index == REG_NUM_ROWS) begin
        num_rows <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_NUM_COLS) begin
        num_cols <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept && rows_loaded < CNT_W'(MAX_ROWS)) begin
            rows_loaded <= rows_loaded + CNT_W'(1);
          end
          row        <= '0;
          dir_up     <= 1'b0;
          first_pass <= 1'b1;
          changed    <= 1'b0;
          behind     <= '0;
        end
        ST_SW_WR: begin
          if (pass_end) begin
            dir_up     <= !dir_up;
            first_pass <= 1'b0;
            changed    <= 1'b0;
            behind     <= '0;
            if (state_next == ST_EMIT) begin
              row <= '0;
            end
          end else begin
            row     <= ahead;
            behind  <= new_row;
            changed <= changed || (new_row != old_row);
          end
        end
        ST_EMIT: begin
          emit_vld  <= 1'b1;
          emit_row  <= row;
          emit_last <= (row == h_last);
          if (row == h_last) begin
            rows_loaded <= '0;
          end else begin
            row <= row + ROW_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    done             = emit_vld;
    dout.row_index   = emit_row;
    dout.filled_bits = keep_a;
    dout.last_out    = emit_last;
  end

  `BCRF_ASSERT_NEXT(a_emit_from_emit_state, state == ST_EMIT, done)
  `BCRF_ASSERT_NOW(a_last_frees_unit, done && dout.last_out, !busy)
  `BCRF_ASSERT_NOW(a_sweep_row_in_grid, state == ST_SW_WR, {1'b0, row} < h)
  `BCRF_ASSERT_NEXT(a_plain_row_stays_idle, accept && !din.last_row, state == ST_IDLE)

endmodule
